/* rtl/cps_pkg.sv */
// Shared types and constants for the CPU process scheduler.
// No dependencies; imported by the scheduler top level.
`timescale 1ns / 1ps

package cps_pkg;

    localparam int PROC_MAX_DEF  = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int PID_BITS      = 4;
    localparam int PID_SLOTS     = 16;
    localparam int BURST_BITS    = 16;
    localparam int WAIT_BITS     = 16;
    localparam int SLICE_BITS    = 8;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_RR   = 2'd1;
    localparam logic [1:0] MODE_SJF  = 2'd2;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_SLICE  = 1'b1;

    typedef enum logic [1:0] {
        EV_ARRIVED  = 2'd0,
        EV_SELECTED = 2'd1,
        EV_FINISHED = 2'd2,
        EV_IDLE     = 2'd3
    } t_ev_kind;

    typedef struct packed {
        t_ev_kind                kind;
        logic [15:0]             etime;
        logic [PID_BITS-1:0]     pid;
        logic [BURST_BITS-1:0]   rem;
        logic [WAIT_BITS-1:0]    wt;
    } t_event;

endpackage

/* rtl/cps_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module cps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cpu_process_scheduler_unit.sv */
// CPU process scheduler top level: sequencer, per-process state RAM and ready queue RAM.
// Depends on cps_pkg and cps_ram.
// An arrival is put at the queue tail or, when the queue is kept sorted (SJF), after a scan for
// its place and a shift of the later entries, one entry per step through the queue RAM. A
// preemption puts the preempted process back into the sorted queue the same way. One request
// is worked on at a time (busy high).
// Each result is strobed for one cycle, in the cycle after the next result of its request is made or
// after the request's last cycle; the receiver cannot stall.
// Synchronous active-low reset empties the queue and clears time, slice and running state.
`timescale 1ns / 1ps

module cpu_process_scheduler_unit
    import cps_pkg::*;
#(
    parameter int PROC_MAX  = PROC_MAX_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_op,
    input  logic [PID_BITS-1:0]   i_pid,
    input  logic [BURST_BITS-1:0] i_burst_length,
    output logic                  o_event_valid,
    output logic [1:0]            o_event_kind,
    output logic [15:0]           o_event_time,
    output logic [PID_BITS-1:0]   o_event_pid,
    output logic [BURST_BITS-1:0] o_remaining_burst,
    output logic [WAIT_BITS-1:0]  o_total_wait,
    output logic                  o_last_of_run
);

    localparam int TB  = TIME_BITS;
    localparam int QAW = $clog2(PROC_MAX);
    localparam int CW  = $clog2(PROC_MAX + 1);
    localparam int SW  = ((TB > WAIT_BITS) ? TB : WAIT_BITS) + 1;
    localparam int PW  = BURST_BITS + WAIT_BITS + TB;
    localparam int NS  = 33;

    typedef struct packed {
        logic [BURST_BITS-1:0] burst;
        logic [WAIT_BITS-1:0]  wt;
        logic [TB-1:0]         lrt;
    } t_pent;

    typedef enum logic [NS-1:0] {
        S_IDLE     = NS'(1) << 0,
        S_AR_WR    = NS'(1) << 1,
        S_AR_EMIT  = NS'(1) << 2,
        S_T1_CHK   = NS'(1) << 3,
        S_T1_SEL   = NS'(1) << 4,
        S_T2_CHK   = NS'(1) << 5,
        S_T2_CMP1  = NS'(1) << 6,
        S_T2_CMP2  = NS'(1) << 7,
        S_T2_LRD   = NS'(1) << 8,
        S_T2_LWR   = NS'(1) << 9,
        S_T2_SEL   = NS'(1) << 10,
        S_T3_RD    = NS'(1) << 11,
        S_T3_CHK   = NS'(1) << 12,
        S_T3_SEL   = NS'(1) << 13,
        S_T4_CHK   = NS'(1) << 14,
        S_T4_LRD   = NS'(1) << 15,
        S_T4_LWR   = NS'(1) << 16,
        S_T4_PUSH  = NS'(1) << 17,
        S_T4_SEL   = NS'(1) << 18,
        S_T5_RD    = NS'(1) << 19,
        S_T5_DEC   = NS'(1) << 20,
        S_T5_END   = NS'(1) << 21,
        S_FIN      = NS'(1) << 22,
        S_PO_RD    = NS'(1) << 23,
        S_PO_GET   = NS'(1) << 24,
        S_SE_RD    = NS'(1) << 25,
        S_SE_UPD   = NS'(1) << 26,
        S_PU_START = NS'(1) << 27,
        S_PU_SC_Q  = NS'(1) << 28,
        S_PU_SC_P  = NS'(1) << 29,
        S_PU_SC_C  = NS'(1) << 30,
        S_PU_SH    = NS'(1) << 31,
        S_PU_SH_W  = NS'(1) << 32
    } t_state;

    // Configuration registers
    logic [1:0]            r_mode;
    logic [SLICE_BITS-1:0] r_slice_cfg;

    // Scheduler state and sequencer registers
    t_state                r_state, n_state;
    t_state                r_ret, n_ret;
    logic [QAW-1:0]        r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [PID_BITS-1:0]   r_run, n_run;
    logic                  r_run_v, n_run_v;
    logic [TB-1:0]         r_time, n_time;
    logic [SLICE_BITS-1:0] r_slice, n_slice;
    logic                  r_fin, n_fin;
    logic [PID_BITS-1:0]   r_pid_in, n_pid_in;
    logic [BURST_BITS-1:0] r_burst_in, n_burst_in;
    logic [BURST_BITS-1:0] r_key, n_key;
    logic [PID_BITS-1:0]   r_push_pid, n_push_pid;
    logic                  r_sorted, n_sorted;
    logic [PID_BITS-1:0]   r_sel, n_sel;
    logic [PID_BITS-1:0]   r_next, n_next;
    logic [PID_BITS-1:0]   r_prev, n_prev;
    logic [CW-1:0]         r_i, n_i;
    logic [CW-1:0]         r_pos, n_pos;
    logic [CW-1:0]         r_j, n_j;

    // Result staging
    t_event                r_pend;
    logic                  r_pend_v;
    t_event                r_out;
    logic                  r_out_v;
    logic                  r_out_last;

    // Memory ports
    logic                  p_we;
    logic [PID_BITS-1:0]   p_waddr, p_raddr;
    t_pent                 p_wdata, p_rdata;
    logic [PW-1:0]         p_rdata_raw;
    logic                  q_we;
    logic [QAW-1:0]        q_waddr, q_raddr;
    logic [PID_BITS-1:0]   q_wdata, q_rdata;

    logic                  emit;
    t_event                ev;
    logic [TB+15:0]        time_ext;
    logic [15:0]           t16;
    logic [TB-1:0]         wdiff;
    logic [SW-1:0]         wsum;
    logic [WAIT_BITS-1:0]  wsat;
    logic [SLICE_BITS-1:0] quantum;
    logic                  is_rr, is_sjf, cfg_wr;

    function automatic logic [QAW-1:0] f_phys(input logic [QAW-1:0] head,
                                              input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(off);
        if (s >= (CW+1)'(PROC_MAX)) begin
            s = s - (CW+1)'(PROC_MAX);
        end
        return s[QAW-1:0];
    endfunction

    cps_ram #(.WIDTH(PW), .DEPTH(PID_SLOTS)) u_pmem (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata_raw)
    );
    assign p_rdata = p_rdata_raw;

    cps_ram #(.WIDTH(PID_BITS), .DEPTH(PROC_MAX)) u_qmem (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    assign is_rr   = (r_mode == MODE_RR);
    assign is_sjf  = (r_mode == MODE_SJF);
    assign quantum = (r_slice_cfg == '0) ? SLICE_BITS'(1) : r_slice_cfg;
    assign time_ext = {16'b0, r_time};
    assign t16      = time_ext[15:0];
    assign wdiff    = r_time - p_rdata.lrt;
    assign wsum     = SW'(p_rdata.wt) + SW'(wdiff);
    assign wsat     = (wsum > SW'({WAIT_BITS{1'b1}})) ? {WAIT_BITS{1'b1}} : wsum[WAIT_BITS-1:0];
    assign busy     = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_head     = r_head;
        n_count    = r_count;
        n_run      = r_run;
        n_run_v    = r_run_v;
        n_time     = r_time;
        n_slice    = r_slice;
        n_fin      = r_fin;
        n_pid_in   = r_pid_in;
        n_burst_in = r_burst_in;
        n_key      = r_key;
        n_push_pid = r_push_pid;
        n_sorted   = r_sorted;
        n_sel      = r_sel;
        n_next     = r_next;
        n_prev     = r_prev;
        n_i        = r_i;
        n_pos      = r_pos;
        n_j        = r_j;
        p_we       = 1'b0;
        p_waddr    = '0;
        p_wdata    = '0;
        p_raddr    = '0;
        q_we       = 1'b0;
        q_waddr    = '0;
        q_wdata    = '0;
        q_raddr    = '0;
        emit       = 1'b0;
        ev         = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_pid_in   = i_pid;
                    n_burst_in = i_burst_length;
                    n_fin      = 1'b0;
                    n_state    = (i_op == OP_ARRIVE) ? S_AR_WR : S_T1_CHK;
                end
            end
            S_AR_WR: begin
                if (r_count >= CW'(PROC_MAX)) begin
                    n_state = S_FIN;
                end else begin
                    p_we       = 1'b1;
                    p_waddr    = r_pid_in;
                    p_wdata    = '{burst: r_burst_in, wt: '0, lrt: r_time};
                    n_key      = r_burst_in;
                    n_push_pid = r_pid_in;
                    n_sorted   = is_sjf;
                    n_ret      = S_AR_EMIT;
                    n_state    = S_PU_START;
                end
            end
            S_AR_EMIT: begin
                emit    = 1'b1;
                ev      = '{kind: EV_ARRIVED, etime: t16, pid: r_pid_in, rem: r_burst_in,
                            wt: '0};
                n_state = S_FIN;
            end
            S_T1_CHK: begin
                if (!r_run_v && r_count != '0) begin
                    n_ret   = S_T1_SEL;
                    n_state = S_PO_RD;
                end else begin
                    n_state = S_T2_CHK;
                end
            end
            S_T1_SEL: begin
                n_sel   = r_next;
                n_ret   = S_T2_CHK;
                n_state = S_SE_RD;
            end
            S_T2_CHK: begin
                if (is_sjf && r_run_v && r_count != '0) begin
                    q_raddr = r_head;
                    p_raddr = r_run;
                    n_state = S_T2_CMP1;
                end else begin
                    n_state = S_T3_RD;
                end
            end
            S_T2_CMP1: begin
                n_key   = p_rdata.burst;
                p_raddr = q_rdata;
                n_state = S_T2_CMP2;
            end
            S_T2_CMP2: begin
                // Preempt only when the running burst is strictly longer than the queue head.
                if (r_key > p_rdata.burst) begin
                    n_prev  = r_run;
                    n_ret   = S_T2_LRD;
                    n_state = S_PO_RD;
                end else begin
                    n_state = S_T3_RD;
                end
            end
            S_T2_LRD: begin
                p_raddr = r_prev;
                n_state = S_T2_LWR;
            end
            S_T2_LWR: begin
                p_we       = 1'b1;
                p_waddr    = r_prev;
                p_wdata    = '{burst: p_rdata.burst, wt: p_rdata.wt, lrt: r_time};
                n_key      = p_rdata.burst;
                n_push_pid = r_prev;
                n_sorted   = 1'b1;
                n_ret      = S_T2_SEL;
                n_state    = S_PU_START;
            end
            S_T2_SEL: begin
                n_sel   = r_next;
                n_ret   = S_T3_RD;
                n_state = S_SE_RD;
            end
            S_T3_RD: begin
                if (r_run_v) begin
                    p_raddr = r_run;
                    n_state = S_T3_CHK;
                end else begin
                    n_state = S_T4_CHK;
                end
            end
            S_T3_CHK: begin
                n_state = S_T4_CHK;
                if (p_rdata.burst == '0) begin
                    emit    = 1'b1;
                    ev      = '{kind: EV_FINISHED, etime: t16, pid: r_run, rem: '0,
                                wt: p_rdata.wt};
                    n_run_v = 1'b0;
                    if (is_rr) begin
                        n_slice = '0;
                        n_fin   = 1'b1;
                    end
                    if (r_count != '0) begin
                        n_ret   = S_T3_SEL;
                        n_state = S_PO_RD;
                    end
                end
            end
            S_T3_SEL: begin
                n_sel   = r_next;
                n_ret   = S_T4_CHK;
                n_state = S_SE_RD;
            end
            S_T4_CHK: begin
                n_state = S_T5_RD;
                if (is_rr && !r_fin && r_slice >= quantum) begin
                    n_slice = '0;
                    if (r_run_v) begin
                        n_prev  = r_run;
                        n_state = S_T4_LRD;
                    end
                end
            end
            S_T4_LRD: begin
                p_raddr = r_prev;
                n_state = S_T4_LWR;
            end
            S_T4_LWR: begin
                p_we    = 1'b1;
                p_waddr = r_prev;
                p_wdata = '{burst: p_rdata.burst, wt: p_rdata.wt, lrt: r_time};
                n_key   = p_rdata.burst;
                if (r_count != '0) begin
                    n_ret   = S_T4_PUSH;
                    n_state = S_PO_RD;
                end else begin
                    // Quantum expired with nobody waiting: the same process is selected again.
                    n_sel   = r_prev;
                    n_ret   = S_T5_RD;
                    n_state = S_SE_RD;
                end
            end
            S_T4_PUSH: begin
                n_push_pid = r_prev;
                n_sorted   = 1'b0;
                n_ret      = S_T4_SEL;
                n_state    = S_PU_START;
            end
            S_T4_SEL: begin
                n_sel   = r_next;
                n_ret   = S_T5_RD;
                n_state = S_SE_RD;
            end
            S_T5_RD: begin
                if (r_run_v) begin
                    p_raddr = r_run;
                    n_state = S_T5_DEC;
                end else begin
                    emit    = 1'b1;
                    ev      = '{kind: EV_IDLE, etime: t16, pid: '0, rem: '0, wt: '0};
                    n_state = S_T5_END;
                end
            end
            S_T5_DEC: begin
                if (p_rdata.burst != '0) begin
                    p_we    = 1'b1;
                    p_waddr = r_run;
                    p_wdata = '{burst: p_rdata.burst - BURST_BITS'(1), wt: p_rdata.wt,
                                lrt: p_rdata.lrt};
                end
                n_state = S_T5_END;
            end
            S_T5_END: begin
                if (r_slice != {SLICE_BITS{1'b1}}) begin
                    n_slice = r_slice + SLICE_BITS'(1);
                end
                n_time  = r_time + TB'(1);
                n_state = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            S_PO_RD: begin
                q_raddr = r_head;
                n_state = S_PO_GET;
            end
            S_PO_GET: begin
                n_next  = q_rdata;
                n_head  = (r_head == QAW'(PROC_MAX - 1)) ? '0 : r_head + QAW'(1);
                n_count = r_count - CW'(1);
                n_state = r_ret;
            end
            S_SE_RD: begin
                p_raddr = r_sel;
                n_state = S_SE_UPD;
            end
            S_SE_UPD: begin
                p_we    = 1'b1;
                p_waddr = r_sel;
                p_wdata = '{burst: p_rdata.burst, wt: wsat, lrt: p_rdata.lrt};
                emit    = 1'b1;
                ev      = '{kind: EV_SELECTED, etime: t16, pid: r_sel, rem: p_rdata.burst,
                            wt: '0};
                n_run   = r_sel;
                n_run_v = 1'b1;
                n_slice = '0;
                n_state = r_ret;
            end
            S_PU_START: begin
                if (r_count >= CW'(PROC_MAX)) begin
                    n_state = r_ret;
                end else if (r_sorted) begin
                    n_i     = '0;
                    n_state = S_PU_SC_Q;
                end else begin
                    n_pos   = r_count;
                    n_j     = r_count;
                    n_state = S_PU_SH;
                end
            end
            S_PU_SC_Q: begin
                if (r_i == r_count) begin
                    n_pos   = r_count;
                    n_j     = r_count;
                    n_state = S_PU_SH;
                end else begin
                    q_raddr = f_phys(r_head, r_i);
                    n_state = S_PU_SC_P;
                end
            end
            S_PU_SC_P: begin
                p_raddr = q_rdata;
                n_state = S_PU_SC_C;
            end
            S_PU_SC_C: begin
                // The new entry goes after every entry with an equal burst.
                if (p_rdata.burst > r_key) begin
                    n_pos   = r_i;
                    n_j     = r_count;
                    n_state = S_PU_SH;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_PU_SC_Q;
                end
            end
            S_PU_SH: begin
                if (r_j == r_pos) begin
                    q_we    = 1'b1;
                    q_waddr = f_phys(r_head, r_pos);
                    q_wdata = r_push_pid;
                    n_count = r_count + CW'(1);
                    n_state = r_ret;
                end else begin
                    q_raddr = f_phys(r_head, r_j - CW'(1));
                    n_state = S_PU_SH_W;
                end
            end
            S_PU_SH_W: begin
                q_we    = 1'b1;
                q_waddr = f_phys(r_head, r_j);
                q_wdata = q_rdata;
                n_j     = r_j - CW'(1);
                n_state = S_PU_SH;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_run   <= '0;
            r_run_v <= 1'b0;
            r_time  <= '0;
            r_slice <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_head  <= n_head;
            r_count <= n_count;
            r_run   <= n_run;
            r_run_v <= n_run_v;
            r_time  <= n_time;
            r_slice <= n_slice;
            r_fin   <= n_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid_in   <= n_pid_in;
        r_burst_in <= n_burst_in;
        r_key      <= n_key;
        r_push_pid <= n_push_pid;
        r_sorted   <= n_sorted;
        r_sel      <= n_sel;
        r_next     <= n_next;
        r_prev     <= n_prev;
        r_i        <= n_i;
        r_pos      <= n_pos;
        r_j        <= n_j;
    end

    // Each result is held back by one so that the final one of a request can be marked.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else if (emit) begin
            r_out_v  <= r_pend_v;
            r_pend_v <= 1'b1;
        end else if (r_state == S_FIN && r_pend_v) begin
            r_out_v  <= 1'b1;
            r_pend_v <= 1'b0;
        end else begin
            r_out_v  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out      <= r_pend;
            r_out_last <= 1'b0;
            r_pend     <= ev;
        end else if (r_state == S_FIN) begin
            r_out      <= r_pend;
            r_out_last <= 1'b1;
        end
    end

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_FCFS;
            r_slice_cfg <= SLICE_BITS'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_POLICY) begin
                r_mode <= pwdata[1:0];
            end else begin
                r_slice_cfg <= pwdata[SLICE_BITS-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SLICE) ? {24'b0, r_slice_cfg} : {30'b0, r_mode};

    assign o_event_valid     = r_out_v;
    assign o_event_kind      = r_out.kind;
    assign o_event_time      = r_out.etime;
    assign o_event_pid       = r_out.pid;
    assign o_remaining_burst = r_out.rem;
    assign o_total_wait      = r_out.wt;
    assign o_last_of_run     = r_out_last;

    a_out_in_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid |-> $past(busy))
        else $error("result strobe outside a request");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(PROC_MAX))
        else $error("ready count beyond queue depth");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= QAW'(PROC_MAX - 1))
        else $error("queue head out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_idle_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("result left pending after a request");

endmodule
